// ===== src/gsig_pkg.sv =====
// Package for the grid strip index generator.
// Holds the job type passed from the front end to the emitter, and the shared constants.
// No dependencies.
`timescale 1ns / 1ps

package gsig_pkg;

	localparam int IDX_W      = 16;
	localparam int CFG_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CNT_W      = 9;
	localparam int JOB_DEPTH  = 4;
	localparam int JOB_PTR_W  = 2;
	localparam int JOB_CNT_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic             triple;
		logic             done;
	} job_t;

endpackage

// ===== src/gsig_front.sv =====
// Front end of the grid strip index generator: configuration registers and strip state.
// Classifies each accepted item and pushes one job per item that causes results.
// Depends on gsig_pkg.
`timescale 1ns / 1ps

module gsig_front import gsig_pkg::*; #(
	parameter int MAX_ROWS = 255,
	parameter int MAX_COLS = 255
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 cfg_ready,
	input  logic                 item_valid,
	input  logic                 restart,
	input  logic                 job_full,
	output logic                 job_push,
	output job_t                 job
);

	logic [CFG_W-1:0] grid_rows_q;
	logic [CFG_W-1:0] grid_cols_q;
	logic [IDX_W-1:0] index_q;
	logic [CNT_W-1:0] countdown_q;
	logic             go_forward_q;
	logic             go_right_q;
	logic [CNT_W-1:0] rows_fin_q;
	logic             started_q;
	logic             finished_q;

	logic [CFG_W-1:0] eff_rows;
	logic [CFG_W-1:0] eff_cols;
	logic [IDX_W-1:0] cols_inc;
	logic [IDX_W-1:0] next_idx;
	logic [CNT_W-1:0] countdown_dec;
	logic [CNT_W-1:0] reload;
	logic [CNT_W-1:0] rows_inc;
	logic             rows_done;
	logic             accept;
	logic             start_now;

	assign cfg_ready = 1'b1;

	always_comb begin
		eff_rows = (32'(grid_rows_q) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : grid_rows_q;
		eff_cols = (32'(grid_cols_q) > MAX_COLS) ? CFG_W'(MAX_COLS) : grid_cols_q;
		cols_inc = {{(IDX_W-CFG_W){1'b0}}, eff_cols} + IDX_W'(1);
		if (go_forward_q) begin
			next_idx = index_q + cols_inc;
		end else if (go_right_q) begin
			next_idx = index_q - cols_inc + IDX_W'(1);
		end else begin
			next_idx = index_q - cols_inc - IDX_W'(1);
		end
		countdown_dec = countdown_q - CNT_W'(1);
		reload        = {eff_cols, 1'b1};
		rows_inc      = rows_fin_q + CNT_W'(1);
		rows_done     = rows_inc >= {1'b0, eff_rows};
		accept        = item_valid && !job_full;
		start_now     = restart || !started_q;

		job_push   = 1'b0;
		job.index  = next_idx;
		job.triple = 1'b0;
		job.done   = 1'b0;
		if (accept) begin
			if (start_now) begin
				job_push   = 1'b1;
				job.index  = '0;
				job.done   = (eff_rows == '0);
			end else if (!finished_q) begin
				job_push = 1'b1;
				if (countdown_dec == '0) begin
					job.triple = 1'b1;
					job.done   = rows_done;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= CFG_W'(1);
			grid_cols_q <= CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GRID_ROWS: grid_rows_q <= cfg_data;
				REG_GRID_COLS: grid_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q      <= '0;
			countdown_q  <= CNT_W'(3);
			go_forward_q <= 1'b1;
			go_right_q   <= 1'b1;
			rows_fin_q   <= '0;
			started_q    <= 1'b0;
			finished_q   <= 1'b0;
		end else if (accept) begin
			if (start_now) begin
				index_q      <= '0;
				countdown_q  <= reload;
				go_forward_q <= 1'b1;
				go_right_q   <= 1'b1;
				rows_fin_q   <= '0;
				started_q    <= 1'b1;
				finished_q   <= (eff_rows == '0);
			end else if (!finished_q) begin
				index_q <= next_idx;
				if (countdown_dec == '0) begin
					go_forward_q <= 1'b1;
					go_right_q   <= !go_right_q;
					countdown_q  <= reload;
					rows_fin_q   <= rows_inc;
					finished_q   <= rows_done;
				end else begin
					go_forward_q <= !go_forward_q;
					countdown_q  <= countdown_dec;
				end
			end
		end
	end

endmodule

// ===== src/gsig_job_fifo.sv =====
// Short job queue between the front end and the emitter of the grid strip index generator.
// Depends on gsig_pkg.
`timescale 1ns / 1ps

module gsig_job_fifo import gsig_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	output logic full,
	input  logic rd_en,
	output job_t rd_job,
	output logic empty
);

	job_t                 mem_q [JOB_DEPTH];
	logic [JOB_PTR_W-1:0] wr_ptr_q;
	logic [JOB_PTR_W-1:0] rd_ptr_q;
	logic [JOB_CNT_W-1:0] count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign full   = (count_q == JOB_CNT_W'(JOB_DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + JOB_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + JOB_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + JOB_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - JOB_CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/gsig_back.sv =====
// Emitter of the grid strip index generator: expands each job into one or three results.
// Depends on gsig_pkg.
`timescale 1ns / 1ps

module gsig_back import gsig_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  job_t             head,
	input  logic             head_empty,
	input  logic             pop,
	output logic             head_pop,
	output logic [IDX_W-1:0] vertex_index,
	output logic             run_last,
	output logic             mesh_done
);

	logic [1:0] rep_q;
	logic       take;

	always_comb begin
		vertex_index = head.index;
		run_last     = head.triple ? (rep_q == 2'd2) : 1'b1;
		mesh_done    = head.done && run_last;
		take         = pop && !head_empty;
		head_pop     = take && run_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_q <= '0;
		end else if (take) begin
			rep_q <= run_last ? 2'd0 : rep_q + 2'd1;
		end
	end

endmodule

// ===== src/grid_strip_index_generator_top.sv =====
// Top level of the grid strip index generator.
// Instantiates gsig_front, gsig_job_fifo and gsig_back; depends on gsig_pkg.
`timescale 1ns / 1ps

// Usage:
// Items enter on push/full with one bit, restart; an item is taken when push is
// high and full is low. Each item is one step of a serpentine triangle strip over
// a grid_rows by grid_cols grid of quads and causes zero, one or three results.
// Results leave on empty/pop: while empty is low, vertex_index, run_last and
// mesh_done show the oldest result, which is taken when pop is high.
// Configuration is written on cfg_valid/cfg_ready with cfg_index and cfg_data
// (index 0 grid_rows, index 1 grid_cols); cfg_ready is always high; the user
// must make writes only while the block is idle; the block does not enforce it.
// Accepted items are registered as jobs in the queue. The front end takes one
// item per cycle while full is low; the emitter gives one result per cycle
// while pop is high, so a row-end item gives three results. A four-entry job
// queue lets the front end run ahead; full rises when that queue is full, e.g.
// while the receiver holds pop low. Reset empties the queue, sets both registers
// to one and clears the strip state, so the first step emits index zero.

module grid_strip_index_generator_top import gsig_pkg::*; #(
	parameter int MAX_ROWS = 255,
	parameter int MAX_COLS = 255
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 push,
	output logic                 full,
	input  logic                 restart,
	output logic                 empty,
	input  logic                 pop,
	output logic [IDX_W-1:0]     vertex_index,
	output logic                 run_last,
	output logic                 mesh_done
);

	job_t job_in;
	job_t job_head;
	logic job_push;
	logic job_pop;

	gsig_front #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.item_valid(push),
		.restart   (restart),
		.job_full  (full),
		.job_push  (job_push),
		.job       (job_in)
	);

	gsig_job_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (job_push),
		.wr_job(job_in),
		.full  (full),
		.rd_en (job_pop),
		.rd_job(job_head),
		.empty (empty)
	);

	gsig_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (job_head),
		.head_empty  (empty),
		.pop         (pop),
		.head_pop    (job_pop),
		.vertex_index(vertex_index),
		.run_last    (run_last),
		.mesh_done   (mesh_done)
	);

`ifndef SYNTHESIS
	a_not_full_and_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(full && empty)) else $error("queue is full and empty at once");

	a_repeat_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !run_last) |=> (!empty && $stable(vertex_index)))
		else $error("repeated result missing or changed");

	a_restart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && restart && empty) |=> (!empty && vertex_index == '0))
		else $error("restart did not emit index zero");
`endif

endmodule
